// ----- rtl/sld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants of the frame deframer
// Phase and sequencer codes, status codes, item kinds, register indexes,
// crc constants and the header event from the parser to the output sequencer.
// ----------------------------------------------------------------------------
package sld_pkg;

    // frame status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_END_ERR  = 2'd1;
    localparam t_status ST_CRC_ERR  = 2'd2;
    localparam t_status ST_SIZE_ERR = 2'd3;

    // result item kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // configuration register indexes
    localparam logic [7:0] REG_START_MARKER = 8'd0;
    localparam logic [7:0] REG_END_MARKER   = 8'd1;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // parser phases
    typedef enum logic [6:0] {
        PH_HUNT   = 7'b0000001,
        PH_SIZE   = 7'b0000010,
        PH_OPCODE = 7'b0000100,
        PH_DATA   = 7'b0001000,
        PH_CRC_LO = 7'b0010000,
        PH_CRC_HI = 7'b0100000,
        PH_END    = 7'b1000000
    } t_phase;

    // output sequencer states
    typedef enum logic [2:0] {
        ES_IDLE = 3'b001,
        ES_OUT  = 3'b010,
        ES_READ = 3'b100
    } t_emit_state;

    // end-of-frame event from the parser
    typedef struct packed {
        t_status    status;
        logic [7:0] opcode;
        logic [7:0] length;
        logic       replay;
    } t_hdr;

endpackage
`default_nettype wire

// ----- rtl/sld_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sld_ram: generic single-port-write, single-port-read ram
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sld_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sld_parser: frame parser with running crc
// Walks the frame one byte at a time, writes payload bytes to the ram and
// raises a header event at the end of a frame or on an oversize length.
// ----------------------------------------------------------------------------
module sld_parser
    import sld_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [7:0]            i_cfg_index,
    input  wire logic [7:0]            i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_byte,
    output logic                       o_wr_en,
    output logic [((PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1)-1:0] o_wr_addr,
    output logic [7:0]                 o_wr_data,
    output logic                       o_hdr_valid,
    output t_hdr                       o_hdr
);

    localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);
    localparam logic [7:0] MAX_LEN = 8'(PAYLOAD_MAX);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_start, r_end;
    logic [7:0]       r_size, n_size;
    logic [7:0]       r_opcode, n_opcode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_rx_crc, n_rx_crc;
    logic [15:0]      crc_fed;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign crc_fed   = crc_feed(r_crc, i_byte);
    assign count_inc = r_count + 1'b1;
    assign o_wr_addr = r_count[ADDR_W-1:0];
    assign o_wr_data = i_byte;

    // marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 8'h00;
            r_end   <= 8'h00;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_MARKER: r_start <= i_cfg_data;
                REG_END_MARKER:   r_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase sequencing
    always_comb begin
        n_phase     = r_phase;
        n_size      = r_size;
        n_opcode    = r_opcode;
        n_count     = r_count;
        n_crc       = r_crc;
        n_rx_crc    = r_rx_crc;
        o_wr_en     = 1'b0;
        o_hdr_valid = 1'b0;
        o_hdr       = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == r_start) begin
                        n_phase = PH_SIZE;
                        n_crc   = CRC_INIT;
                        n_count = '0;
                    end
                end
                PH_SIZE: begin
                    n_size = i_byte;
                    if (i_byte > MAX_LEN) begin
                        o_hdr_valid  = 1'b1;
                        o_hdr.status = ST_SIZE_ERR;
                        o_hdr.length = i_byte;
                        n_phase      = PH_HUNT;
                    end else begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_OPCODE: begin
                    n_opcode = i_byte;
                    n_crc    = crc_fed;
                    n_count  = '0;
                    n_phase  = (r_size == 8'h00) ? PH_CRC_LO : PH_DATA;
                end
                PH_DATA: begin
                    o_wr_en = 1'b1;
                    n_crc   = crc_fed;
                    n_count = count_inc;
                    if (8'(count_inc) >= r_size) begin
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    n_rx_crc = {8'h00, i_byte};
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    n_rx_crc = {i_byte, r_rx_crc[7:0]};
                    n_phase  = PH_END;
                end
                PH_END: begin
                    o_hdr_valid  = 1'b1;
                    o_hdr.opcode = r_opcode;
                    o_hdr.length = r_size;
                    if (i_byte != r_end) begin
                        o_hdr.status = ST_END_ERR;
                    end else if (r_crc != r_rx_crc) begin
                        o_hdr.status = ST_CRC_ERR;
                    end else begin
                        o_hdr.status = ST_OK;
                        o_hdr.replay = (r_size != 8'h00);
                    end
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_size   <= 8'h00;
            r_opcode <= 8'h00;
            r_count  <= '0;
            r_crc    <= CRC_INIT;
            r_rx_crc <= 16'h0000;
        end else begin
            r_phase  <= n_phase;
            r_size   <= n_size;
            r_opcode <= n_opcode;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_rx_crc <= n_rx_crc;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sld_emitter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sld_emitter: result sequencer
// Holds the header word in the output register, then replays the buffered
// payload from the ram, one read and one output word per byte.
// ----------------------------------------------------------------------------
module sld_emitter
    import sld_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_hdr_valid,
    input  wire t_hdr              i_hdr,
    output logic                   o_busy,
    output logic                   o_rd_en,
    output logic [((PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1)-1:0] o_rd_addr,
    input  wire logic [7:0]        i_rd_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_kind,
    output t_status                o_status,
    output logic [7:0]             o_opcode,
    output logic [7:0]             o_length,
    output logic [7:0]             o_byte,
    output logic                   o_last
);

    localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);

    t_emit_state      r_state, n_state;
    logic [CNT_W-1:0] r_left, n_left;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic             r_kind, n_kind;
    t_status          r_status, n_status;
    logic [7:0]       r_opcode, n_opcode;
    logic [7:0]       r_length, n_length;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;

    assign o_busy    = (r_state != ES_IDLE);
    assign o_valid   = (r_state == ES_OUT);
    assign o_rd_addr = r_addr;
    assign o_kind    = r_kind;
    assign o_status  = r_status;
    assign o_opcode  = r_opcode;
    assign o_length  = r_length;
    assign o_byte    = r_byte;
    assign o_last    = r_last;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_addr   = r_addr;
        n_kind   = r_kind;
        n_status = r_status;
        n_opcode = r_opcode;
        n_length = r_length;
        n_byte   = r_byte;
        n_last   = r_last;
        o_rd_en  = 1'b0;
        unique case (r_state)
            ES_IDLE: begin
                if (i_hdr_valid) begin
                    n_kind   = KIND_HEADER;
                    n_status = i_hdr.status;
                    n_opcode = i_hdr.opcode;
                    n_length = i_hdr.length;
                    n_byte   = 8'h00;
                    n_last   = !i_hdr.replay;
                    n_left   = i_hdr.replay ? i_hdr.length[CNT_W-1:0] : '0;
                    n_addr   = '0;
                    n_state  = ES_OUT;
                end
            end
            ES_OUT: begin
                if (i_ready) begin
                    if (r_left != '0) begin
                        o_rd_en = 1'b1;
                        n_state = ES_READ;
                    end else begin
                        n_state = ES_IDLE;
                    end
                end
            end
            ES_READ: begin
                // ram data for r_addr is ready this cycle
                n_kind   = KIND_DATA;
                n_status = ST_OK;
                n_opcode = 8'h00;
                n_length = 8'h00;
                n_byte   = i_rd_data;
                n_last   = (r_left == CNT_W'(1));
                n_left   = r_left - 1'b1;
                n_addr   = r_addr + 1'b1;
                n_state  = ES_OUT;
            end
            default: begin
                n_state = ES_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
            r_left  <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_addr  <= n_addr;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_opcode <= n_opcode;
        r_length <= n_length;
        r_byte   <= n_byte;
        r_last   <= n_last;
    end

endmodule
`default_nettype wire

// ----- rtl/sync_length_crc_frame_deframer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_crc_frame_deframer: length-prefixed frame deframer, crc-16
// Receives a byte stream, frames it by start marker, size, opcode, payload,
// little-endian crc-16/ccitt-false and end marker, and delivers a header word
// for each frame, followed by the payload of each good frame.
// ----------------------------------------------------------------------------
// Usage: input bytes are taken one per cycle while no result is pending.
// At the end of a frame (or on an oversize length byte) a header word is
// placed in the output register and input is held off until the whole
// result run, marked by tlast, has been taken. A good frame with a payload
// then replays its bytes from the payload ram, each byte passing through
// the registered ram read and then the output register; the next byte is
// read only after the previous word has been taken. The payload ram needs
// no clearing after reset. Header words carry status 0 ok, 1 end marker
// missing, 2 crc mismatch, 3 size too large (opcode 0); data words carry
// the payload byte only. Markers are to be written through the configuration
// port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_deframer
    import sld_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // received byte stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [7:0] rx_byte
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,    // [1:0] frame_status, [9:2] frame_opcode,
                                           // [17:10] payload_length,
                                           // [25:18] payload_byte, [31:26] zero
    output logic             o_m_tuser,    // [0] item_kind
    output logic             o_m_tlast     // last_item
);

    localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic              accept;
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              hdr_valid;
    t_hdr              hdr;
    t_status           out_status;
    logic [7:0]        out_opcode;
    logic [7:0]        out_length;
    logic [7:0]        out_byte;

    // input held off during result delivery, so ram reads and writes never meet
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !busy;
    assign accept      = i_s_tvalid && o_s_tready;

    sld_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_hdr_valid (hdr_valid),
        .o_hdr       (hdr)
    );

    sld_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sld_emitter #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr_valid (hdr_valid),
        .i_hdr       (hdr),
        .o_busy      (busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (o_m_tuser),
        .o_status    (out_status),
        .o_opcode    (out_opcode),
        .o_length    (out_length),
        .o_byte      (out_byte),
        .o_last      (o_m_tlast)
    );

    // result word packing
    assign o_m_tdata = {6'b000000, out_byte, out_length, out_opcode, out_status};

`ifndef ASSERT_OFF
    // no byte is taken while a result word waits
    a_stall_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input accepted while a result word is pending");

    // a run ends with its tlast word
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> !o_m_tvalid)
        else $error("result word follows the last word of a frame");

    // a failed frame gives a header only
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && (o_m_tdata[1:0] != ST_OK)) |-> o_m_tlast)
        else $error("error header not marked last");

    // data words carry no status, opcode or length
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[17:0] == 18'h0))
        else $error("data word with header fields set");
`endif

endmodule
`default_nettype wire

// ----- tb/sync_length_crc_frame_deframer_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_crc_frame_deframer_tb: self-checking bench for the frame deframer
// A short table of frames exercises the size limits, the end marker and crc
// error paths and an empty payload under the reset markers, then random
// frame traffic under several marker settings. Every result word is compared
// with its table row or a behavioural predictor of parser and payload replay.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_deframer_tb;
    import sld_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int PAYLOAD_DEPTH = 32;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 73;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;

    // one result word, as the predictor expects it
    typedef struct packed {
        logic       kind;
        t_status    status;
        logic [7:0] opcode;
        logic [7:0] length;
        logic [7:0] pbyte;
        logic       last;
    } t_frame_item;

    // how a directed row picks its byte
    typedef enum logic [1:0] {
        ROW_BYTE    = 2'd0,
        ROW_CRC_LO  = 2'd1,
        ROW_CRC_HI  = 2'd2,
        ROW_CRC_BAD = 2'd3
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  value;
        logic        typed;
        t_frame_item item;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data = 8'h00;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tready = 1'b0;
    wire        cfg_ready;
    wire        s_tready;
    wire        m_tvalid;
    wire [31:0] m_tdata;
    wire        m_tuser;
    wire        m_tlast;

    // predictor state
    t_phase      rx_phase = PH_HUNT;
    logic [7:0]  start_marker_q = 8'h00;
    logic [7:0]  end_marker_q = 8'h00;
    logic [7:0]  size_q = 8'h00;
    logic [7:0]  opcode_q = 8'h00;
    int          pay_count = 0;
    logic [15:0] crc_acc = CRC_INIT;
    logic [15:0] crc_rx = 16'h0000;
    logic [7:0]  pay_store [PAYLOAD_DEPTH];

    t_frame_item new_items[$];
    t_frame_item expected_items[$];
    t_dir_row    dir_rows[$];

    int err_count = 0;
    int bytes_sent = 0;
    int data_words = 0;
    int hdr_by_status [4] = '{0, 0, 0, 0};
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit hold_rx = 1'b0;

    sync_length_crc_frame_deframer #(
        .PAYLOAD_MAX(PAYLOAD_DEPTH)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // clock
    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // crc-16/ccitt-false over one byte, msb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic t_frame_item header_item(input t_status st, input logic [7:0] opc,
                                                input logic [7:0] len);
        t_frame_item it;
        it        = '0;
        it.kind   = KIND_HEADER;
        it.status = st;
        it.opcode = opc;
        it.length = len;
        it.last   = 1'b1;
        return it;
    endfunction

    function automatic t_frame_item payload_item(input logic [7:0] b, input logic last);
        t_frame_item it;
        it       = '0;
        it.kind  = KIND_DATA;
        it.pbyte = b;
        it.last  = last;
        return it;
    endfunction

    // parser and replay predictor: one received byte in, its result words out
    task automatic deframe_byte(input logic [7:0] b);
        t_frame_item it;
        int          i;
        new_items.delete();
        case (rx_phase)
            PH_HUNT: begin
                if (b == start_marker_q) begin
                    rx_phase  = PH_SIZE;
                    crc_acc   = CRC_INIT;
                    pay_count = 0;
                end
            end
            PH_SIZE: begin
                size_q = b;
                if (b > PAYLOAD_DEPTH) begin
                    new_items.push_back(header_item(ST_SIZE_ERR, 8'h00, b));
                    rx_phase = PH_HUNT;
                end else begin
                    rx_phase = PH_OPCODE;
                end
            end
            PH_OPCODE: begin
                opcode_q  = b;
                crc_acc   = crc16_step(crc_acc, b);
                pay_count = 0;
                rx_phase  = (size_q == 8'h00) ? PH_CRC_LO : PH_DATA;
            end
            PH_DATA: begin
                if (pay_count < PAYLOAD_DEPTH) pay_store[pay_count] = b;
                crc_acc   = crc16_step(crc_acc, b);
                pay_count = pay_count + 1;
                if (pay_count >= size_q) rx_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                crc_rx   = {8'h00, b};
                rx_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                crc_rx[15:8] = b;
                rx_phase     = PH_END;
            end
            PH_END: begin
                // end marker is judged before the crc
                if (b != end_marker_q) begin
                    new_items.push_back(header_item(ST_END_ERR, opcode_q, size_q));
                end else if (crc_acc != crc_rx) begin
                    new_items.push_back(header_item(ST_CRC_ERR, opcode_q, size_q));
                end else begin
                    it      = header_item(ST_OK, opcode_q, size_q);
                    it.last = (size_q == 8'h00);
                    new_items.push_back(it);
                    for (i = 0; i < size_q && i < PAYLOAD_DEPTH; i++) begin
                        new_items.push_back(payload_item(pay_store[i], (i + 1 == size_q)));
                    end
                end
                rx_phase = PH_HUNT;
            end
            default: rx_phase = PH_HUNT;
        endcase
    endtask

    // offer one byte, wait for it to be taken, then predict
    task automatic send_rx_byte(input logic [7:0] b, input logic typed,
                                input t_frame_item typed_item);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        deframe_byte(b);
        if (typed) begin
            expected_items.push_back(typed_item);
        end else begin
            foreach (new_items[i]) expected_items.push_back(new_items[i]);
        end
    endtask

    // register write, valid left high for a following write
    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_START_MARKER) start_marker_q = val;
        else if (idx == REG_END_MARKER) end_marker_q = val;
    endtask

    // stop sending and let every outstanding result word come back
    task automatic drain_results();
        int w;
        s_tvalid <= 1'b0;
        @(posedge clk);
        for (w = 0; w < DRAIN_LIMIT && expected_items.size() != 0; w++) @(posedge clk);
        if (expected_items.size() != 0) begin
            $error("%0d result words never arrived", expected_items.size());
            err_count++;
            expected_items.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random frame, mostly well formed, sometimes broken or just noise
    task automatic send_random_frame();
        logic [7:0]  fb[$];
        logic [7:0]  b;
        logic [15:0] crc;
        int          pick;
        int          sel;
        int          size;
        int          keep;
        int          k;
        pick    = $urandom_range(0, 99);
        tx_calm = ($urandom_range(0, 3) == 0);
        if (pick < 8) begin
            repeat ($urandom_range(1, 4)) begin
                b = $urandom_range(0, 255);
                send_rx_byte(b, 1'b0, '0);
            end
            return;
        end
        sel = $urandom_range(0, 19);
        if (sel < 14) size = $urandom_range(0, 8);
        else if (sel < 16) size = PAYLOAD_DEPTH;
        else if (sel < 17) size = $urandom_range(9, PAYLOAD_DEPTH - 1);
        else size = $urandom_range(PAYLOAD_DEPTH + 1, 255);
        fb.push_back(start_marker_q);
        fb.push_back(size[7:0]);
        if (size <= PAYLOAD_DEPTH) begin
            b = $urandom_range(0, 255);
            fb.push_back(b);
            crc = crc16_step(CRC_INIT, b);
            for (k = 0; k < size; k++) begin
                b = $urandom_range(0, 255);
                fb.push_back(b);
                crc = crc16_step(crc, b);
            end
            if (pick < 18) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
            b = end_marker_q;
            if (pick >= 18 && pick < 28) b = end_marker_q ^ 8'($urandom_range(1, 255));
            fb.push_back(b);
            // cut short: the next frame's bytes land mid-frame
            if (pick >= 28 && pick < 33) begin
                keep = $urandom_range(2, fb.size() - 2);
                while (fb.size() > keep) void'(fb.pop_back());
            end
        end
        foreach (fb[i]) send_rx_byte(fb[i], 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge clk) begin
        t_frame_item want;
        if (rst_n && m_tvalid && m_tready) begin
            if (m_tuser == KIND_DATA) data_words++;
            else hdr_by_status[m_tdata[1:0]]++;
            if (expected_items.size() == 0) begin
                $error("unexpected result word 0x%08h user %0b last %0b",
                       m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = expected_items.pop_front();
                check_field("item_kind", want.kind, m_tuser);
                check_field("frame_status", want.status, m_tdata[1:0]);
                check_field("frame_opcode", want.opcode, m_tdata[9:2]);
                check_field("payload_length", want.length, m_tdata[17:10]);
                check_field("payload_byte", want.pbyte, m_tdata[25:18]);
                check_field("tdata_pad", 0, m_tdata[31:26]);
                check_field("last_item", want.last, m_tlast);
            end
        end
    end

    // result sink with random stalls and one long hold-off
    initial begin : result_sink
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // stimulus
    initial begin : stimulus
        t_dir_row   row;
        logic [7:0] b;
        logic [7:0] start_set [PHASE_COUNT];
        logic [7:0] end_set [PHASE_COUNT];
        int         p;
        int         phase_base;
        bit         paused;

        // directed table, markers still at their reset value of zero
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'hFF, 1'b1, header_item(ST_SIZE_ERR, 8'h00, 8'hFF)};
        dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h21, 1'b1, header_item(ST_SIZE_ERR, 8'h00, 8'h21)};
        dir_rows.push_back(row);
        // empty payload, good crc
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'hA5, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_CRC_LO, 8'h00, 1'b0, '0};                            dir_rows.push_back(row);
        row = '{ROW_CRC_HI, 8'h00, 1'b0, '0};                            dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h00, 1'b1, header_item(ST_OK, 8'hA5, 8'h00)};
        dir_rows.push_back(row);
        // wrong end marker wins over a good crc
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'hFF, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_CRC_LO, 8'h00, 1'b0, '0};                            dir_rows.push_back(row);
        row = '{ROW_CRC_HI, 8'h00, 1'b0, '0};                            dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h7E, 1'b1, header_item(ST_END_ERR, 8'hFF, 8'h00)};
        dir_rows.push_back(row);
        // crc mismatch with the right end marker
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h00, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h12, 1'b0, '0};                              dir_rows.push_back(row);
        row = '{ROW_CRC_BAD, 8'h00, 1'b0, '0};                           dir_rows.push_back(row);
        row = '{ROW_CRC_HI, 8'h00, 1'b0, '0};                            dir_rows.push_back(row);
        row = '{ROW_BYTE, 8'h00, 1'b1, header_item(ST_CRC_ERR, 8'h12, 8'h00)};
        dir_rows.push_back(row);

        // marker settings of the random phases, extremes and equal pairs included
        start_set = '{8'h7E, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
        end_set   = '{8'h81, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
        start_set[4] = $urandom_range(0, 255);
        end_set[4]   = $urandom_range(0, 255);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_rows[k]) begin
            case (dir_rows[k].kind)
                ROW_CRC_LO:  b = crc_acc[7:0];
                ROW_CRC_HI:  b = crc_acc[15:8];
                ROW_CRC_BAD: b = crc_acc[7:0] ^ 8'h01;
                default:     b = dir_rows[k].value;
            endcase
            send_rx_byte(b, dir_rows[k].typed, dir_rows[k].item);
        end

        // random phases, markers rewritten while idle
        for (p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            cfg_write(REG_START_MARKER, start_set[p]);
            cfg_write(REG_END_MARKER, end_set[p]);
            // an index past the register map must be ignored
            cfg_write(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
            cfg_valid <= 1'b0;
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (p == 1) hold_rx = 1'b1;
            phase_base = bytes_sent;
            paused     = 1'b0;
            while (bytes_sent - phase_base < PHASE_ITEMS) begin
                send_random_frame();
                // sender pause until everything outstanding is back
                if (p == 3 && !paused && bytes_sent - phase_base >= PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (expected_items.size() != 0) @(posedge clk);
                    paused = 1'b1;
                end
            end
        end
        drain_results();

        $display("sent %0d bytes over %0d marker settings after the directed frames",
                 bytes_sent, PHASE_COUNT + 1);
        $display("headers ok %0d, end error %0d, crc error %0d, size error %0d; %0d payload words",
                 hdr_by_status[0], hdr_by_status[1], hdr_by_status[2], hdr_by_status[3],
                 data_words);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(2 * CLK_HALF * 1500000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/sld_pkg.sv
rtl/sld_ram.sv
rtl/sld_parser.sv
rtl/sld_emitter.sv
rtl/sync_length_crc_frame_deframer.sv
tb/sync_length_crc_frame_deframer_tb.sv
